// File: design/ray_triangle_intersect_unit_defines.svh
// Assertion macros for the ray/triangle intersection unit.
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define RTI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define RTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rti_pkg.sv
// Shared constants and types of the ray/triangle intersection unit.
package rti_pkg;

   // Fraction bits of the distance t and width of the quotient
   localparam int T_FRAC    = 16;
   localparam int QUO_W     = 32;
   localparam int DIST_W    = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [DIST_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [DIST_W-1:0] Q_MIN     = 32'sh8000_0000;
   localparam logic        [QUO_W-1:0]  Q_HALF    = 32'h8000_0000;
   localparam logic signed [DIST_W-1:0] MISS_DIST = -32'sd65536;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VERTEX_A     = 2'd0,
      REG_VERTEX_B     = 2'd1,
      REG_VERTEX_C     = 2'd2,
      REG_PLANE_NORMAL = 2'd3
   } csr_reg_type;

endpackage

// File: design/ray_triangle_intersect_unit.sv
// Ray/triangle intersection unit: fully pipelined, one ray per cycle.
//
// Rays enter on the req_ channel (origin and direction, signed fixed point,
// COORD_BITS each) with a valid/ready handshake; one result per ray leaves on
// the rsp_ channel: rsp_hit and rsp_distance (t in signed Q16.16, saturated,
// -1.0 on a miss). The triangle (vertices A, B, C and plane normal N) sits in
// four registers written through csr_. The user must write them only while
// no ray is in flight; the block does not enforce this. Throughput: one ray
// per cycle. The depth is set by the radix-2 divider for t (32 stages, one
// quotient bit each) plus the split 2-D multiplies of the barycentric test.
// The pipeline advances as one: when the output holds a result that is not
// taken, every stage holds and req_ready drops; bubbles are carried as
// cleared valid bits, so nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and the triangle
// registers to zero. Triangle changes pass through the registered edge vectors
// before they reach the derived edge products.
module ray_triangle_intersect_unit #(
   parameter int COORD_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_origin_x,
   input  logic signed [COORD_BITS-1:0]        req_origin_y,
   input  logic signed [COORD_BITS-1:0]        req_origin_z,
   input  logic signed [COORD_BITS-1:0]        req_dir_x,
   input  logic signed [COORD_BITS-1:0]        req_dir_y,
   input  logic signed [COORD_BITS-1:0]        req_dir_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic signed [rti_pkg::DIST_W-1:0]   rsp_distance,
   input  logic                                csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [3*COORD_BITS-1:0]             csr_wr_data
);
   import rti_pkg::*;

`include "ray_triangle_intersect_unit_defines.svh"

   localparam int CW   = COORD_BITS;
   localparam int RGW  = 3 * CW;
   localparam int EW   = CW + 1;            // A - O
   localparam int PW   = 2 * CW + 1;        // single products of stage 1
   localparam int NW   = 2 * CW + 3;        // num, den
   localparam int MW   = NW;                // magnitudes
   localparam int XW   = MW + T_FRAC;       // dividend
   localparam int HW   = XW - QUO_W;        // dividend bits above quotient
   localparam int QDW  = QUO_W + CW;        // t * D
   localparam int SHW  = QDW - T_FRAC;
   localparam int V2W  = SHW + 2;           // P - A
   localparam int V0W  = CW + 1;            // edges
   localparam int D0W  = 2 * V0W + 2;       // d00, d01, d11
   localparam int VPW  = V0W + V2W;
   localparam int DW   = VPW + 2;           // common dot width
   localparam int LOW  = DW / 2;
   localparam int HIW  = DW - LOW;
   localparam int PRW  = 2 * DW;
   localparam int SW   = PRW + 2;

   // Stage map
   localparam int ST_DIV = 5;
   localparam int ST_SAT = ST_DIV + QUO_W;
   localparam int ST_QD  = ST_SAT + 1;
   localparam int ST_V2  = ST_QD + 1;
   localparam int ST_VP  = ST_V2 + 1;
   localparam int ST_DS  = ST_VP + 1;
   localparam int ST_PP  = ST_DS + 1;
   localparam int ST_PS  = ST_PP + 1;
   localparam int ST_NU  = ST_PS + 1;
   localparam int ST_NM  = ST_NU + 1;
   localparam int ST_FL  = ST_NM + 1;
   localparam int ST_OUT = ST_FL + 1;
   localparam int NS     = ST_OUT + 1;

   typedef struct packed {
      logic [2:0][CW-1:0] o;
      logic [2:0][CW-1:0] d;
   } ray_type;

   typedef struct packed {
      logic [MW-1:0]    r;
      logic [MW-1:0]    y;
      logic [QUO_W-1:0] l;
      logic [QUO_W-1:0] qa;
      logic             ovf;
      logic             neg;
   } div_type;

   function automatic logic signed [CW-1:0] crd(input logic [RGW-1:0] r, input int k);
      crd = $signed(r[k*CW +: CW]);
   endfunction

   // Triangle registers
   logic [RGW-1:0] va_ff, vb_ff, vc_ff, vn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
         vc_ff <= '0;
         vn_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_VERTEX_A:     va_ff <= csr_wr_data;
            REG_VERTEX_B:     vb_ff <= csr_wr_data;
            REG_VERTEX_C:     vc_ff <= csr_wr_data;
            REG_PLANE_NORMAL: vn_ff <= csr_wr_data;
            default:          va_ff <= va_ff;
         endcase
      end
   end

   // Edge vectors and their dot products, derived from the triangle
   logic signed [V0W-1:0] cv0_ff [3], cv1_ff [3];
   logic signed [D0W-1:0] cd00_ff, cd01_ff, cd11_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         cv0_ff[k] <= V0W'(crd(vc_ff, k)) - V0W'(crd(va_ff, k));
         cv1_ff[k] <= V0W'(crd(vb_ff, k)) - V0W'(crd(va_ff, k));
      end
      cd00_ff <= D0W'(cv0_ff[0]) * D0W'(cv0_ff[0]) + D0W'(cv0_ff[1]) * D0W'(cv0_ff[1])
               + D0W'(cv0_ff[2]) * D0W'(cv0_ff[2]);
      cd01_ff <= D0W'(cv0_ff[0]) * D0W'(cv1_ff[0]) + D0W'(cv0_ff[1]) * D0W'(cv1_ff[1])
               + D0W'(cv0_ff[2]) * D0W'(cv1_ff[2]);
      cd11_ff <= D0W'(cv1_ff[0]) * D0W'(cv1_ff[0]) + D0W'(cv1_ff[1]) * D0W'(cv1_ff[1])
               + D0W'(cv1_ff[2]) * D0W'(cv1_ff[2]);
   end

   // Pipeline control: all stages advance together
   logic          en;
   logic [NS-1:0] v_ff, v_in;

   assign en        = !v_ff[ST_OUT] || rsp_ready;
   assign req_ready = en;
   assign v_in      = {v_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // Payload registers
   ray_type              ray_ff [0:ST_QD];
   ray_type              ray_in [0:ST_QD];
   logic                 live_ff [3:ST_FL];
   logic                 live_in [3:ST_FL];
   logic signed [PW-1:0] pn_ff [3], pn_in [3], pd_ff [3], pd_in [3];
   logic signed [NW-1:0] num_ff, num_in, den_ff, den_in;
   logic [MW-1:0]        nm_ff, nm_in, dm_ff, dm_in;
   logic                 neg_ff, neg_in;
   div_type              dv_ff [ST_DIV-1:ST_SAT-1];
   div_type              dv_in [ST_DIV-1:ST_SAT-1];
   logic [XW-1:0]        xs;
   logic [HW-1:0]        hs;
   logic [MW:0]          rs [ST_DIV:ST_SAT-1];
   logic signed [DIST_W-1:0] q_ff [ST_SAT:ST_FL];
   logic signed [DIST_W-1:0] q_in [ST_SAT:ST_FL];
   logic signed [QDW-1:0] qd_ff [3], qd_in [3];
   logic signed [V2W-1:0] v2_ff [3], v2_in [3];
   logic signed [VPW-1:0] vp0_ff [3], vp0_in [3], vp1_ff [3], vp1_in [3];
   logic signed [DW-1:0]  d02_ff, d02_in, d12_ff, d12_in;
   logic signed [DW-1:0]  ma [6], mb [6];
   logic signed [DW-1:0]  d00x, d01x, d11x;
   logic [2*LOW-1:0]      pll_ff [6], pll_in [6];
   logic signed [DW:0]    plh_ff [6], plh_in [6], phl_ff [6], phl_in [6];
   logic signed [2*HIW-1:0] phh_ff [6], phh_in [6];
   logic [PRW-1:0]        psum [6];
   logic signed [PRW-1:0] pr_ff [6], pr_in [6];
   logic signed [SW-1:0]  nu_ff, nu_in, nv_ff, nv_in, dn_ff, dn_in;
   logic signed [SW-1:0]  nun_ff, nun_in, nvn_ff, nvn_in, dnn_ff, dnn_in;
   logic signed [SW-1:0]  sum_ff, sum_in, dnf_ff, dnf_in;
   logic                  fl_ff, fl_in;
   logic                  hit_ff, hit_in;
   logic signed [DIST_W-1:0] dist_ff, dist_in;

   // Stage logic
   always_comb begin
      // ray capture and carry
      ray_in[0].o[0] = req_origin_x;
      ray_in[0].o[1] = req_origin_y;
      ray_in[0].o[2] = req_origin_z;
      ray_in[0].d[0] = req_dir_x;
      ray_in[0].d[1] = req_dir_y;
      ray_in[0].d[2] = req_dir_z;
      for (int j = 1; j <= ST_QD; j++) ray_in[j] = ray_ff[j-1];

      // stage 1: (A - O) * N and D * N per axis
      for (int k = 0; k < 3; k++) begin
         pn_in[k] = PW'(EW'(crd(va_ff, k)) - EW'($signed(ray_ff[0].o[k])))
                  * PW'(crd(vn_ff, k));
         pd_in[k] = PW'($signed(ray_ff[0].d[k])) * PW'(crd(vn_ff, k));
      end

      // stage 2: plane numerator and denominator
      num_in = NW'(pn_ff[0]) + NW'(pn_ff[1]) + NW'(pn_ff[2]);
      den_in = NW'(pd_ff[0]) + NW'(pd_ff[1]) + NW'(pd_ff[2]);

      // stage 3: magnitudes and quotient sign
      nm_in = num_ff[NW-1] ? MW'(-num_ff) : MW'(num_ff);
      dm_in = den_ff[NW-1] ? MW'(-den_ff) : MW'(den_ff);
      neg_in = num_ff[NW-1] ^ den_ff[NW-1];

      live_in[3] = (den_ff != '0);
      for (int j = 4; j <= ST_FL; j++) live_in[j] = live_ff[j-1];
      live_in[ST_NM] = live_ff[ST_NU] && (dn_ff != '0);

      // stage 4: divider setup and overflow check
      xs = {nm_ff, T_FRAC'(0)};
      hs = xs[XW-1:QUO_W];
      dv_in[ST_DIV-1].r   = MW'(hs);
      dv_in[ST_DIV-1].y   = dm_ff;
      dv_in[ST_DIV-1].l   = xs[QUO_W-1:0];
      dv_in[ST_DIV-1].qa  = '0;
      dv_in[ST_DIV-1].ovf = (MW'(hs) >= dm_ff);
      dv_in[ST_DIV-1].neg = neg_ff;

      // divider: one quotient bit per stage
      for (int j = ST_DIV; j < ST_SAT; j++) begin
         rs[j]       = {dv_ff[j-1].r, dv_ff[j-1].l[QUO_W-1]};
         dv_in[j]    = dv_ff[j-1];
         dv_in[j].l  = {dv_ff[j-1].l[QUO_W-2:0], 1'b0};
         if (rs[j] >= {1'b0, dv_ff[j-1].y}) begin
            dv_in[j].r  = MW'(rs[j] - {1'b0, dv_ff[j-1].y});
            dv_in[j].qa = {dv_ff[j-1].qa[QUO_W-2:0], 1'b1};
         end else begin
            dv_in[j].r  = MW'(rs[j]);
            dv_in[j].qa = {dv_ff[j-1].qa[QUO_W-2:0], 1'b0};
         end
      end

      // saturate and sign the quotient
      if (!dv_ff[ST_SAT-1].neg) begin
         q_in[ST_SAT] = (dv_ff[ST_SAT-1].ovf || dv_ff[ST_SAT-1].qa[QUO_W-1])
                      ? Q_MAX : $signed(dv_ff[ST_SAT-1].qa);
      end else begin
         q_in[ST_SAT] = (dv_ff[ST_SAT-1].ovf || dv_ff[ST_SAT-1].qa > Q_HALF)
                      ? Q_MIN : -$signed(dv_ff[ST_SAT-1].qa);
      end
      for (int j = ST_SAT + 1; j <= ST_FL; j++) q_in[j] = q_ff[j-1];

      // t * D, then hit point relative to A
      for (int k = 0; k < 3; k++) begin
         qd_in[k] = QDW'(q_ff[ST_SAT]) * QDW'($signed(ray_ff[ST_SAT].d[k]));
         v2_in[k] = V2W'($signed(qd_ff[k][QDW-1:T_FRAC])) + V2W'($signed(ray_ff[ST_QD].o[k]))
                  - V2W'(crd(va_ff, k));
         vp0_in[k] = VPW'(cv0_ff[k]) * VPW'(v2_ff[k]);
         vp1_in[k] = VPW'(cv1_ff[k]) * VPW'(v2_ff[k]);
      end
      d02_in = DW'(vp0_ff[0]) + DW'(vp0_ff[1]) + DW'(vp0_ff[2]);
      d12_in = DW'(vp1_ff[0]) + DW'(vp1_ff[1]) + DW'(vp1_ff[2]);

      // wide products as four partial products each
      d00x = DW'(cd00_ff);
      d01x = DW'(cd01_ff);
      d11x = DW'(cd11_ff);
      ma[0] = d11x;  mb[0] = d02_ff;
      ma[1] = d01x;  mb[1] = d12_ff;
      ma[2] = d00x;  mb[2] = d12_ff;
      ma[3] = d01x;  mb[3] = d02_ff;
      ma[4] = d00x;  mb[4] = d11x;
      ma[5] = d01x;  mb[5] = d01x;
      for (int i = 0; i < 6; i++) begin
         pll_in[i] = (2*LOW)'(ma[i][LOW-1:0]) * (2*LOW)'(mb[i][LOW-1:0]);
         plh_in[i] = (DW+1)'($signed({1'b0, ma[i][LOW-1:0]}))
                   * (DW+1)'($signed(mb[i][DW-1:LOW]));
         phl_in[i] = (DW+1)'($signed(ma[i][DW-1:LOW]))
                   * (DW+1)'($signed({1'b0, mb[i][LOW-1:0]}));
         phh_in[i] = (2*HIW)'($signed(ma[i][DW-1:LOW]))
                   * (2*HIW)'($signed(mb[i][DW-1:LOW]));
         psum[i]   = (PRW'(phh_ff[i]) << (2*LOW))
                   + ((PRW'(plh_ff[i]) + PRW'(phl_ff[i])) << LOW)
                   + PRW'(pll_ff[i]);
         pr_in[i]  = $signed(psum[i]);
      end

      // barycentric numerators and common denominator
      nu_in = SW'(pr_ff[0]) - SW'(pr_ff[1]);
      nv_in = SW'(pr_ff[2]) - SW'(pr_ff[3]);
      dn_in = SW'(pr_ff[4]) - SW'(pr_ff[5]);

      // make the denominator positive
      if (dn_ff < 0) begin
         nun_in = -nu_ff;
         nvn_in = -nv_ff;
         dnn_in = -dn_ff;
      end else begin
         nun_in = nu_ff;
         nvn_in = nv_ff;
         dnn_in = dn_ff;
      end

      // inside tests
      fl_in  = (nun_ff > 0) && (nun_ff < dnn_ff) && (nvn_ff > 0) && (nvn_ff < dnn_ff);
      sum_in = nun_ff + nvn_ff;
      dnf_in = dnn_ff;

      hit_in  = live_ff[ST_FL] && fl_ff && (sum_ff <= dnf_ff);
      dist_in = hit_in ? q_ff[ST_FL] : MISS_DIST;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= ST_QD; j++) ray_ff[j] <= ray_in[j];
         for (int j = 3; j <= ST_FL; j++) live_ff[j] <= live_in[j];
         for (int j = ST_DIV - 1; j < ST_SAT; j++) dv_ff[j] <= dv_in[j];
         for (int j = ST_SAT; j <= ST_FL; j++) q_ff[j] <= q_in[j];
         for (int k = 0; k < 3; k++) begin
            pn_ff[k]  <= pn_in[k];
            pd_ff[k]  <= pd_in[k];
            qd_ff[k]  <= qd_in[k];
            v2_ff[k]  <= v2_in[k];
            vp0_ff[k] <= vp0_in[k];
            vp1_ff[k] <= vp1_in[k];
         end
         for (int i = 0; i < 6; i++) begin
            pll_ff[i] <= pll_in[i];
            plh_ff[i] <= plh_in[i];
            phl_ff[i] <= phl_in[i];
            phh_ff[i] <= phh_in[i];
            pr_ff[i]  <= pr_in[i];
         end
         num_ff  <= num_in;
         den_ff  <= den_in;
         nm_ff   <= nm_in;
         dm_ff   <= dm_in;
         neg_ff  <= neg_in;
         d02_ff  <= d02_in;
         d12_ff  <= d12_in;
         nu_ff   <= nu_in;
         nv_ff   <= nv_in;
         dn_ff   <= dn_in;
         nun_ff  <= nun_in;
         nvn_ff  <= nvn_in;
         dnn_ff  <= dnn_in;
         fl_ff   <= fl_in;
         sum_ff  <= sum_in;
         dnf_ff  <= dnf_in;
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid    = v_ff[ST_OUT];
   assign rsp_hit      = hit_ff;
   assign rsp_distance = dist_ff;

   // Checks
   `RTI_ASSERT_NOW(a_miss_dist, clock, reset, rsp_valid && !rsp_hit, rsp_distance == MISS_DIST, "miss without -1.0 distance")
   `RTI_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, v_ff[0], "accepted ray missing from first stage")
   `RTI_ASSERT_NEXT(a_parallel_miss, clock, reset, en && v_ff[ST_FL] && !live_ff[ST_FL], rsp_valid && !rsp_hit, "parallel or degenerate case reported a hit")

endmodule

// File: tb/sv/ray_triangle_checker.sv
// Checker for the ray/triangle unit: tracks the triangle, predicts each result and compares.
module ray_triangle_checker #(
   parameter int COORD_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [COORD_BITS-1:0]      req_origin_x,
   input  logic signed [COORD_BITS-1:0]      req_origin_y,
   input  logic signed [COORD_BITS-1:0]      req_origin_z,
   input  logic signed [COORD_BITS-1:0]      req_dir_x,
   input  logic signed [COORD_BITS-1:0]      req_dir_y,
   input  logic signed [COORD_BITS-1:0]      req_dir_z,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_hit,
   input  logic signed [rti_pkg::DIST_W-1:0] rsp_distance,
   input  logic                              csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [3*COORD_BITS-1:0]           csr_wr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                hit_count,
   output int                                ray_count
);
   import rti_pkg::*;

   typedef logic signed [127:0] wide_type;
   typedef struct {
      logic                     hit;
      logic signed [DIST_W-1:0] distance;
   } hit_rec_type;

   logic [3*COORD_BITS-1:0] tri_reg [4];
   hit_rec_type             expected_hits [$];
   int                      errs = 0;

   assign fail_count = errs;

   // one coordinate out of a packed register, sign extended
   function automatic longint coord(logic [3*COORD_BITS-1:0] r, int k);
      logic signed [COORD_BITS-1:0] c;
      c = r[k*COORD_BITS +: COORD_BITS];
      return longint'(c);
   endfunction

   function automatic longint dot3(longint p[3], longint q[3]);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
   endfunction

   // expected hit flag and distance for one ray against the current triangle
   function automatic hit_rec_type predict_hit(longint o[3], longint d[3]);
      longint      a[3], b[3], c[3], n[3], e[3], v0[3], v1[3], v2[3];
      longint      num, den, q, d00, d01, d11, d02, d12;
      wide_type    dn, nu, nv;
      logic        hit;
      hit_rec_type r;
      hit = 1'b0;
      q = 0;
      for (int k = 0; k < 3; k++) begin
         a[k] = coord(tri_reg[REG_VERTEX_A], k);
         b[k] = coord(tri_reg[REG_VERTEX_B], k);
         c[k] = coord(tri_reg[REG_VERTEX_C], k);
         n[k] = coord(tri_reg[REG_PLANE_NORMAL], k);
         e[k] = a[k] - o[k];
      end
      num = dot3(e, n);
      den = dot3(d, n);
      // ray parallel to the plane is a miss
      if (den != 0) begin
         q = (num * (longint'(1) <<< T_FRAC)) / den;
         if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
         if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
         for (int k = 0; k < 3; k++) begin
            v0[k] = c[k] - a[k];
            v1[k] = b[k] - a[k];
            v2[k] = o[k] + ((q * d[k]) >>> T_FRAC) - a[k];
         end
         d00 = dot3(v0, v0);
         d01 = dot3(v0, v1);
         d11 = dot3(v1, v1);
         d02 = dot3(v0, v2);
         d12 = dot3(v1, v2);
         dn = wide_type'(d00) * wide_type'(d11) - wide_type'(d01) * wide_type'(d01);
         // degenerate triangle is a miss
         if (dn != 0) begin
            nu = wide_type'(d11) * wide_type'(d02) - wide_type'(d01) * wide_type'(d12);
            nv = wide_type'(d00) * wide_type'(d12) - wide_type'(d01) * wide_type'(d02);
            if (dn < 0) begin
               dn = -dn;
               nu = -nu;
               nv = -nv;
            end
            hit = nu > 0 && nu < dn && nv > 0 && nv < dn && nu + nv <= dn;
         end
      end
      r.hit      = hit;
      r.distance = hit ? q[DIST_W-1:0] : MISS_DIST;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errs++;
   endtask

   // track register writes, predict on each ray transfer, compare on each result transfer
   always @(posedge clock) begin
      longint      o[3], d[3];
      hit_rec_type want;
      if (reset) begin
         for (int k = 0; k < 4; k++) tri_reg[k] <= '0;
         expected_hits.delete();
         ray_count <= 0;
         hit_count <= 0;
      end else begin
         if (csr_wr_en) tri_reg[csr_index] <= csr_wr_data;
         if (req_valid && req_ready) begin
            o[0] = req_origin_x; o[1] = req_origin_y; o[2] = req_origin_z;
            d[0] = req_dir_x;    d[1] = req_dir_y;    d[2] = req_dir_z;
            want = predict_hit(o, d);
            expected_hits.push_back(want);
            ray_count <= ray_count + 1;
            if (want.hit) hit_count <= hit_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("result with no ray outstanding");
            end else begin
               want = expected_hits.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit %b, want %b", rsp_hit, want.hit));
               if (rsp_distance !== want.distance)
                  report_mismatch($sformatf("distance %h, want %h",
                                            rsp_distance, want.distance));
            end
         end
      end
      pending <= expected_hits.size();
   end

endmodule

// File: tb/sv/ray_triangle_intersect_unit_tb.sv
// Top of the ray/triangle unit testbench: clock, reset, stimulus and verdict.
module ray_triangle_intersect_unit_tb;
   import rti_pkg::*;

   localparam int CB = 20;
   localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid, req_ready;
   logic signed [CB-1:0]     req_origin_x, req_origin_y, req_origin_z;
   logic signed [CB-1:0]     req_dir_x, req_dir_y, req_dir_z;
   logic                     rsp_valid, rsp_ready;
   logic                     rsp_hit;
   logic signed [DIST_W-1:0] rsp_distance;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [3*CB-1:0]          csr_wr_data;
   int                       fail_count, pending, hit_count, ray_count;
   logic                     no_gaps = 1'b0;
   longint                   tri_a[3], tri_b[3], tri_c[3];

   always #5 clock = ~clock;

   ray_triangle_intersect_unit #(.COORD_BITS(CB)) dut (.*);

   ray_triangle_checker #(.COORD_BITS(CB)) chk (.*);

   function automatic logic [3*CB-1:0] pack3(longint x, longint y, longint z);
      logic [CB-1:0] px, py, pz;
      px = x[CB-1:0];
      py = y[CB-1:0];
      pz = z[CB-1:0];
      return {pz, py, px};
   endfunction

   function automatic longint rand_span(longint lim);
      return longint'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // write all four triangle registers back to back, then let them settle
   task automatic write_triangle(logic [3*CB-1:0] va, logic [3*CB-1:0] vb,
                                 logic [3*CB-1:0] vc, logic [3*CB-1:0] nrm);
      csr_reg_type idx;
      logic [3*CB-1:0] vals[4];
      vals = '{va, vb, vc, nrm};
      // stop the ray stream; nothing may be in flight when the triangle changes
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      for (int k = 0; k < 4; k++) begin
         idx = csr_reg_type'(k);
         csr_wr_en   <= 1'b1;
         csr_index   <= idx;
         csr_wr_data <= vals[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      repeat (4) @(posedge clock);
      for (int k = 0; k < 3; k++) begin
         tri_a[k] = longint'($signed(va[k*CB +: CB]));
         tri_b[k] = longint'($signed(vb[k*CB +: CB]));
         tri_c[k] = longint'($signed(vc[k*CB +: CB]));
      end
   endtask

   // one ray transfer; valid stays high afterward until the next call decides
   task automatic send_ray(longint ox, longint oy, longint oz,
                           longint dx, longint dy, longint dz);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_origin_x <= ox[CB-1:0];
      req_origin_y <= oy[CB-1:0];
      req_origin_z <= oz[CB-1:0];
      req_dir_x    <= dx[CB-1:0];
      req_dir_y    <= dy[CB-1:0];
      req_dir_z    <= dz[CB-1:0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_noise_ray();
      send_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   // ray through a point inside the current triangle (or near an edge)
   task automatic send_aimed_ray();
      longint p[3], o[3], d[3];
      int     wa, wb, flip;
      wa = $urandom_range(0, 16);
      wb = $urandom_range(0, 16 - wa);
      flip = $urandom_range(0, 5);
      for (int k = 0; k < 3; k++) begin
         p[k] = tri_a[k] + (wa * (tri_b[k] - tri_a[k]) + wb * (tri_c[k] - tri_a[k])) / 16;
         o[k] = p[k] + rand_span(65536);
         d[k] = p[k] - o[k];
         if (flip == 0) d[k] = -d[k];
      end
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
   endtask

   // small random triangle; normal is the edge cross product or random
   task automatic random_triangle();
      longint a[3], b[3], c[3], e1[3], e2[3], n[3];
      for (int k = 0; k < 3; k++) begin
         a[k] = rand_span(131072);
         e1[k] = rand_span(400);
         e2[k] = rand_span(400);
         b[k] = a[k] + e1[k];
         c[k] = a[k] + e2[k];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      if ($urandom_range(0, 3) == 0) begin
         n[0] = rand_span(CMAX); n[1] = rand_span(CMAX); n[2] = rand_span(CMAX);
      end
      write_triangle(pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
                     pack3(c[0], c[1], c[2]), pack3(n[0], n[1], n[2]));
   endtask

   // result side: random stall before each transfer
   initial begin
      int gap;
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // run limit
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_valid    <= 1'b0;
      req_origin_x <= '0; req_origin_y <= '0; req_origin_z <= '0;
      req_dir_x    <= '0; req_dir_y    <= '0; req_dir_z    <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= REG_VERTEX_A;
      csr_wr_data  <= '0;
      reset        <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset triangle: all zero, so every ray is parallel and misses
      send_ray(CMAX, CMAX, CMAX, -CMAX - 1, -CMAX - 1, -CMAX - 1);
      send_ray(-CMAX - 1, -CMAX - 1, -CMAX - 1, CMAX, CMAX, CMAX);
      send_ray(0, 0, 0, 0, 0, 0);
      send_ray(-1, -1, -1, 1, 1, 1);

      // unit right triangle in z = 0
      write_triangle(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 1024, 0),
                     pack3(0, 0, 1024));
      send_ray(256, 256, 1024, 0, 0, -1024);     // interior hit, t = 1
      send_ray(256, 256, -2048, 0, 0, -1024);    // interior hit behind origin
      send_ray(2048, 2048, 1024, 0, 0, -1024);   // outside
      send_ray(0, 512, 1024, 0, 0, -1024);       // on an edge
      send_ray(512, 512, 1024, 0, 0, -1024);     // on the hypotenuse
      send_ray(0, 0, 1024, 0, 0, -1024);         // vertex
      send_ray(256, 256, 1024, 1024, 0, 0);      // parallel to the plane
      send_ray(300, 200, 1, 0, 0, -1);           // tiny direction, short distance
      send_ray(300, 200, CMAX, 0, 0, -1);        // distance saturates high
      send_ray(300, 200, -CMAX - 1, 0, 0, -1);   // distance saturates low
      send_ray(100, 100, 512, 200, 300, -512);   // oblique hit

      // degenerate: collinear vertices
      write_triangle(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(2048, 0, 0),
                     pack3(0, 0, 1024));
      send_ray(256, 0, 1024, 0, 0, -1024);
      send_ray(256, 256, 1024, 0, 0, -1024);

      // extreme register values
      write_triangle({3{20'h7FFFF}}, {3{20'h80000}}, {20'h80000, 20'h7FFFF, 20'h00000},
                     (3*CB)'({$urandom(), $urandom()}));
      repeat (60) send_noise_ray();
      write_triangle({3{20'h80000}}, {3{20'hFFFFF}}, {20'h7FFFF, 20'h00001, 20'h80000},
                     {3{20'hFFFFF}});
      repeat (60) send_noise_ray();

      // random triangles, mostly aimed rays
      for (int ph = 0; ph < 6; ph++) begin
         random_triangle();
         no_gaps = (ph % 3 == 1);
         repeat (110) begin
            if ($urandom_range(0, 3) == 0) send_noise_ray();
            else send_aimed_ray();
         end
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (60) @(posedge clock);
      $display("rays sent: %0d, predicted hits: %0d, over 11 triangle settings",
               ray_count, hit_count);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/rti_pkg.sv
design/ray_triangle_intersect_unit.sv
tb/sv/ray_triangle_checker.sv
tb/sv/ray_triangle_intersect_unit_tb.sv
